/* rtl/dlme_pkg.sv */
// ----------------------------------------------------------------------------
// dlme_pkg
// Shared widths, operation codes and sequencer states for the matrix engine.
// ----------------------------------------------------------------------------
package dlme_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int CNT_W    = 7;
    localparam int DATA_W   = 32;
    localparam int ACC_W    = 80;

    typedef logic [2:0] op_t;
    localparam op_t OP_WR_W   = 3'd0;
    localparam op_t OP_WR_R   = 3'd1;
    localparam op_t OP_WR_C   = 3'd2;
    localparam op_t OP_FWD    = 3'd3;
    localparam op_t OP_TRN    = 3'd4;
    localparam op_t OP_UPD    = 3'd5;
    localparam op_t OP_RD_W   = 3'd6;
    localparam op_t OP_RD_V   = 3'd7;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef logic [2:0] state_t;
    localparam state_t ST_IDLE  = 3'd0;
    localparam state_t ST_READ  = 3'd1;
    localparam state_t ST_MUL   = 3'd2;
    localparam state_t ST_ACC   = 3'd3;
    localparam state_t ST_WRITE = 3'd4;
    localparam state_t ST_DONE  = 3'd5;

endpackage

/* rtl/dense_layer_matrix_engine_top.sv */
// ----------------------------------------------------------------------------
// dense_layer_matrix_engine_top
// Weight matrix, row and column vector with element access and three sweeps.
// ----------------------------------------------------------------------------
// Element writes and reads step through accept, memory access (READ state)
// and result load into the output register (DONE state). Forward and transpose
// step through operand read, multiply and accumulate for each matrix element,
// plus a write-back for each target; update adds a write-back for every
// element. All sweeps are bounded by one shared 32x32 multiplier and one 80-bit
// accumulator stepping through the weight memory one word at a time, each word
// accumulated before the next is read. The input is not ready during a sweep.
// The result waits in an output register until taken. The next request is
// accepted while it waits. The block holds in its last cycle if a new result
// would overwrite one not yet taken. Memories hold no reset value.
module dense_layer_matrix_engine_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [5:0]  s_row_index,
    input  logic [5:0]  s_col_index,
    input  logic        s_vector_pick,
    input  logic signed [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_read_value,
    output logic        m_saturated
);

    localparam int AW = dlme_pkg::ROW_W + dlme_pkg::COL_W;

    logic [31:0] wmem [dlme_pkg::MAX_ROWS*dlme_pkg::MAX_COLS];
    logic [31:0] rmem [dlme_pkg::MAX_ROWS];
    logic [31:0] cmem [dlme_pkg::MAX_COLS];

    logic [6:0] rows_reg, cols_reg;
    dlme_pkg::state_t state_reg, state_next;
    logic [2:0] op_reg;
    logic [5:0] ri_reg, ci_reg;
    logic pick_reg;
    logic [31:0] val_reg;
    logic [6:0] o_reg, i_reg, o_next, i_next;
    logic [6:0] nr, nc, nout, nin;
    logic [31:0] wq_reg, rq_reg, cq_reg;
    logic signed [63:0] prod_reg;
    logic signed [79:0] acc_reg, acc_next;
    logic sat_reg, sat_next;
    logic first_reg, first_next;
    logic m_valid_reg;
    logic m_sat_reg;
    logic [31:0] rd_reg;
    logic [5:0] r_idx, c_idx;
    logic [AW-1:0] w_addr;
    logic [31:0] fin;
    logic fin_sat;
    logic is_sweep;
    logic done_go;

    assign nr = (rows_reg > 7'(dlme_pkg::MAX_ROWS)) ? 7'(dlme_pkg::MAX_ROWS) : rows_reg;
    assign nc = (cols_reg > 7'(dlme_pkg::MAX_COLS)) ? 7'(dlme_pkg::MAX_COLS) : cols_reg;
    assign nout = (op_reg == dlme_pkg::OP_TRN) ? nc : nr;
    assign nin  = (op_reg == dlme_pkg::OP_TRN) ? nr : nc;
    assign is_sweep = (op_reg == dlme_pkg::OP_FWD) || (op_reg == dlme_pkg::OP_TRN)
                   || (op_reg == dlme_pkg::OP_UPD);
    assign done_go = (state_reg == dlme_pkg::ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        if (is_sweep) begin
            r_idx = (op_reg == dlme_pkg::OP_TRN) ? i_reg[5:0] : o_reg[5:0];
            c_idx = (op_reg == dlme_pkg::OP_TRN) ? o_reg[5:0] : i_reg[5:0];
        end else begin
            r_idx = ri_reg;
            c_idx = ci_reg;
        end
    end
    assign w_addr = {r_idx, c_idx};

    // floor shift by 16, saturate
    always_comb begin
        logic signed [63:0] sh;
        sh = acc_reg[79:16];
        fin_sat = 1'b0;
        if (sh > 64'sh7FFFFFFF) begin
            fin = 32'h7FFFFFFF;
            fin_sat = 1'b1;
        end else if (sh < -64'sh80000000) begin
            fin = 32'h80000000;
            fin_sat = 1'b1;
        end else begin
            fin = sh[31:0];
        end
    end

    assign s_ready = (state_reg == dlme_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_read_value = rd_reg;
    assign m_saturated = m_sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= 7'd64;
            cols_reg <= 7'd64;
        end else if (cfg_wr_en) begin
            if (cfg_index == dlme_pkg::REG_ROWS) rows_reg <= cfg_data;
            else cols_reg <= cfg_data;
        end
    end

    // memory reads
    always_ff @(posedge aclk) begin
        wq_reg <= wmem[w_addr];
        rq_reg <= rmem[r_idx];
        cq_reg <= cmem[c_idx];
    end

    always_comb begin
        state_next = state_reg;
        o_next = o_reg;
        i_next = i_reg;
        acc_next = acc_reg;
        sat_next = sat_reg;
        first_next = first_reg;
        case (state_reg)
            dlme_pkg::ST_IDLE: begin
                o_next = '0;
                i_next = '0;
                first_next = 1'b1;
                if (s_valid && s_ready) begin
                    state_next = dlme_pkg::ST_READ;
                    sat_next = 1'b0;
                end
            end
            dlme_pkg::ST_READ: begin
                if (!is_sweep || nout == 7'd0 || nin == 7'd0)
                    state_next = dlme_pkg::ST_DONE;
                else
                    state_next = dlme_pkg::ST_MUL;
            end
            dlme_pkg::ST_MUL: state_next = dlme_pkg::ST_ACC;
            dlme_pkg::ST_ACC: begin
                if (op_reg == dlme_pkg::OP_UPD) begin
                    acc_next = {{32{wq_reg[31]}}, wq_reg, 16'd0} + 80'(prod_reg);
                    state_next = dlme_pkg::ST_WRITE;
                end else begin
                    if (first_reg)
                        acc_next = (op_reg == dlme_pkg::OP_FWD)
                            ? {{32{rq_reg[31]}}, rq_reg, 16'd0} + 80'(prod_reg)
                            : {{32{cq_reg[31]}}, cq_reg, 16'd0} + 80'(prod_reg);
                    else
                        acc_next = acc_reg + 80'(prod_reg);
                    first_next = 1'b0;
                    if (i_reg == nin - 7'd1) begin
                        state_next = dlme_pkg::ST_WRITE;
                    end else begin
                        i_next = i_reg + 7'd1;
                        state_next = dlme_pkg::ST_READ;
                    end
                end
            end
            dlme_pkg::ST_WRITE: begin
                sat_next = sat_reg | fin_sat;
                first_next = 1'b1;
                state_next = dlme_pkg::ST_READ;
                if (op_reg == dlme_pkg::OP_UPD) begin
                    if (i_reg == nin - 7'd1) begin
                        i_next = '0;
                        if (o_reg == nout - 7'd1) state_next = dlme_pkg::ST_DONE;
                        else o_next = o_reg + 7'd1;
                    end else begin
                        i_next = i_reg + 7'd1;
                    end
                end else begin
                    i_next = '0;
                    if (o_reg == nout - 7'd1) state_next = dlme_pkg::ST_DONE;
                    else o_next = o_reg + 7'd1;
                end
            end
            dlme_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = dlme_pkg::ST_IDLE;
            end
            default: state_next = dlme_pkg::ST_IDLE;
        endcase
    end

    // MUL state follows READ, so the operand read at the new address is registered first
    logic mul_go;
    logic [31:0] ma, mb;
    always_comb begin
        case (op_reg)
            dlme_pkg::OP_FWD: begin ma = wq_reg; mb = cq_reg; end
            dlme_pkg::OP_TRN: begin ma = wq_reg; mb = rq_reg; end
            default:          begin ma = rq_reg; mb = cq_reg; end
        endcase
    end
    assign mul_go = (state_reg == dlme_pkg::ST_MUL);

    always_ff @(posedge aclk) begin
        if (mul_go)
            prod_reg <= $signed(ma) * $signed(mb);
    end

    // ST_MUL follows ST_READ, where the address settles, so q regs are valid
    always_ff @(posedge aclk) begin
        if (state_reg == dlme_pkg::ST_WRITE) begin
            if (op_reg == dlme_pkg::OP_UPD) wmem[w_addr] <= fin;
            else if (op_reg == dlme_pkg::OP_FWD) rmem[r_idx] <= fin;
            else cmem[c_idx] <= fin;
        end else if (state_reg == dlme_pkg::ST_READ) begin
            case (op_reg)
                dlme_pkg::OP_WR_W: wmem[w_addr] <= val_reg;
                dlme_pkg::OP_WR_R: rmem[r_idx] <= val_reg;
                dlme_pkg::OP_WR_C: cmem[c_idx] <= val_reg;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg <= s_operation;
            ri_reg <= s_row_index;
            ci_reg <= s_col_index;
            pick_reg <= s_vector_pick;
            val_reg <= s_value;
        end
        acc_reg <= acc_next;
        if (done_go) begin
            m_sat_reg <= sat_reg;
            case (op_reg)
                dlme_pkg::OP_RD_W: rd_reg <= wq_reg;
                dlme_pkg::OP_RD_V: rd_reg <= pick_reg ? cq_reg : rq_reg;
                default:           rd_reg <= '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dlme_pkg::ST_IDLE;
            o_reg <= '0;
            i_reg <= '0;
            sat_reg <= 1'b0;
            first_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            o_reg <= o_next;
            i_reg <= i_next;
            sat_reg <= sat_next;
            first_reg <= first_next;
            if (done_go) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != dlme_pkg::ST_IDLE) |-> !s_ready)
        else $error("request accepted while busy");
    a_done_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dlme_pkg::ST_DONE) |=> m_valid)
        else $error("result not presented after done");
    a_sat_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == dlme_pkg::ST_DONE)
            && (op_reg == dlme_pkg::OP_RD_W || op_reg == dlme_pkg::OP_RD_V))
            |-> !sat_reg)
        else $error("saturation on a read");

endmodule

/* verif/dense_layer_matrix_engine_top_tb.sv */
// ----------------------------------------------------------------------------
// dense_layer_matrix_engine_top_tb
// Self-checking bench for the matrix engine. It loads a corner of the store,
// then runs a directed table and random traffic across several row/column
// counts, including zero, one, the maximum and counts above the maximum. Every
// result is checked against a Q16.16 GEMV / rank-1 update predictor or the
// typed answer of its table row. Both handshakes see random bursts, gaps and stalls.
// ----------------------------------------------------------------------------
module dense_layer_matrix_engine_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LOAD_N = 8;
    localparam logic signed [127:0] Q_MAX = 128'sh7FFFFFFF;
    localparam logic signed [127:0] Q_MIN = -128'sh80000000;

    typedef struct packed {
        logic [31:0] read_value;
        logic        saturated;
    } answer_t;

    typedef struct {
        dlme_pkg::op_t op;
        logic [5:0]  ri;
        logic [5:0]  ci;
        logic        pick;
        logic [31:0] val;
        bit          typed;
        answer_t     ans;
    } vector_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [6:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_operation;
    logic [5:0]  s_row_index;
    logic [5:0]  s_col_index;
    logic        s_vector_pick;
    logic signed [31:0] s_value;
    logic        m_valid;
    logic        m_ready;
    logic signed [31:0] m_read_value;
    logic        m_saturated;

    dense_layer_matrix_engine_top u_top (.*);

    logic [31:0] w_mem [dlme_pkg::MAX_ROWS][dlme_pkg::MAX_COLS];
    logic [31:0] r_vec [dlme_pkg::MAX_ROWS];
    logic [31:0] c_vec [dlme_pkg::MAX_COLS];
    int          rows_cnt = 64;
    int          cols_cnt = 64;

    answer_t     pending_answers[$];
    int          mismatches = 0;
    int          accepted   = 0;
    int          sweeps     = 0;
    int          sat_seen   = 0;
    int          cycles     = 0;
    int          burst_left = 0;
    bit          long_hold_req = 0;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Floor shift by 16, then clamp to signed 32 bits.
    function automatic logic [31:0] fold_q16(input logic signed [127:0] acc, inout bit sat);
        logic signed [127:0] s;
        s = acc >>> 16;
        if (s > Q_MAX) begin
            sat = 1;
            return 32'h7FFFFFFF;
        end
        if (s < Q_MIN) begin
            sat = 1;
            return 32'h80000000;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [127:0] wide(input logic [31:0] v);
        logic signed [31:0] sv;
        sv = v;
        return 128'(sv);
    endfunction

    function automatic answer_t engine_predict(input dlme_pkg::op_t op, input logic [5:0] ri,
                                               input logic [5:0] ci, input logic pick,
                                               input logic [31:0] val);
        answer_t a;
        logic signed [127:0] acc;
        bit sat;
        int nr, nc;
        nr = rows_cnt > dlme_pkg::MAX_ROWS ? dlme_pkg::MAX_ROWS : rows_cnt;
        nc = cols_cnt > dlme_pkg::MAX_COLS ? dlme_pkg::MAX_COLS : cols_cnt;
        sat = 0;
        a = '0;
        case (op)
            dlme_pkg::OP_WR_W: w_mem[ri][ci] = val;
            dlme_pkg::OP_WR_R: r_vec[ri] = val;
            dlme_pkg::OP_WR_C: c_vec[ci] = val;
            dlme_pkg::OP_FWD: begin
                for (int r = 0; r < nr; r++) begin
                    acc = wide(r_vec[r]) <<< 16;
                    for (int c = 0; c < nc; c++) acc += wide(w_mem[r][c]) * wide(c_vec[c]);
                    r_vec[r] = fold_q16(acc, sat);
                end
            end
            dlme_pkg::OP_TRN: begin
                for (int c = 0; c < nc; c++) begin
                    acc = wide(c_vec[c]) <<< 16;
                    for (int r = 0; r < nr; r++) acc += wide(w_mem[r][c]) * wide(r_vec[r]);
                    c_vec[c] = fold_q16(acc, sat);
                end
            end
            dlme_pkg::OP_UPD: begin
                for (int r = 0; r < nr; r++)
                    for (int c = 0; c < nc; c++) begin
                        acc = (wide(w_mem[r][c]) <<< 16) + wide(r_vec[r]) * wide(c_vec[c]);
                        w_mem[r][c] = fold_q16(acc, sat);
                    end
            end
            dlme_pkg::OP_RD_W: a.read_value = w_mem[ri][ci];
            default: a.read_value = pick ? c_vec[ci] : r_vec[ri];
        endcase
        a.saturated = sat;
        return a;
    endfunction

    task automatic send_req(input dlme_pkg::op_t op, input logic [5:0] ri,
                            input logic [5:0] ci, input logic pick, input logic [31:0] val,
                            input bit typed = 0, input answer_t typed_ans = '0);
        answer_t a;
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_row_index   <= ri;
        s_col_index   <= ci;
        s_vector_pick <= pick;
        s_value       <= val;
        do @(posedge aclk); while (!s_ready);
        a = engine_predict(op, ri, ci, pick, val);
        pending_answers.push_back(typed ? typed_ans : a);
        accepted++;
        if (op inside {dlme_pkg::OP_FWD, dlme_pkg::OP_TRN, dlme_pkg::OP_UPD}) sweeps++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_counts(input logic [6:0] rows, input logic [6:0] cols);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= dlme_pkg::REG_ROWS;
        cfg_data  <= rows;
        @(posedge aclk);
        cfg_index <= dlme_pkg::REG_COLS;
        cfg_data  <= cols;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        rows_cnt = rows;
        cols_cnt = cols;
    endtask

    function automatic logic [31:0] rand_q16();
        if ($urandom_range(0, 7) == 0) return $urandom();
        return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h/%b", m_read_value,
                                               m_saturated);
            end else begin
                answer_t e;
                e = pending_answers.pop_front();
                if (m_saturated) sat_seen++;
                if (e.read_value !== m_read_value || e.saturated !== m_saturated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch at %0t: expected %h/%b, got %h/%b", $realtime,
                                 e.read_value, e.saturated, m_read_value, m_saturated);
                end
            end
        end
    end

    initial begin
        int cnt;
        m_ready <= 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                long_hold_req = 0;
            end else begin
                cnt++;
                if ((cnt / 64) % 3 == 0) m_ready <= 1'b1;
                else m_ready <= $urandom_range(0, 2) != 0;
            end
        end
    end

    vector_row_t directed[] = '{
        '{dlme_pkg::OP_WR_W, 6'd0,  6'd0,  1'b0, 32'h7FFFFFFF, 1, '{32'h0, 1'b0}},
        '{dlme_pkg::OP_RD_W, 6'd0,  6'd0,  1'b0, 32'h0,        1, '{32'h7FFFFFFF, 1'b0}},
        '{dlme_pkg::OP_WR_W, 6'd63, 6'd63, 1'b0, 32'h80000000, 1, '{32'h0, 1'b0}},
        '{dlme_pkg::OP_RD_W, 6'd63, 6'd63, 1'b1, 32'hFFFFFFFF, 1, '{32'h80000000, 1'b0}},
        '{dlme_pkg::OP_WR_R, 6'd63, 6'd0,  1'b0, 32'hFFFFFFFF, 1, '{32'h0, 1'b0}},
        '{dlme_pkg::OP_RD_V, 6'd63, 6'd5,  1'b0, 32'h0,        1, '{32'hFFFFFFFF, 1'b0}},
        '{dlme_pkg::OP_WR_C, 6'd9,  6'd0,  1'b0, 32'h00010000, 1, '{32'h0, 1'b0}},
        '{dlme_pkg::OP_RD_V, 6'd9,  6'd0,  1'b1, 32'h0,        1, '{32'h00010000, 1'b0}},
        '{dlme_pkg::OP_WR_R, 6'd0,  6'd0,  1'b0, 32'h7FFFFFFF, 1, '{32'h0, 1'b0}},
        '{dlme_pkg::OP_FWD,  6'd0,  6'd0,  1'b0, 32'h0,        0, '{32'h0, 1'b0}},
        '{dlme_pkg::OP_RD_V, 6'd0,  6'd0,  1'b0, 32'h0,        0, '{32'h0, 1'b0}},
        '{dlme_pkg::OP_WR_R, 6'd1,  6'd0,  1'b0, 32'hFFFF0000, 1, '{32'h0, 1'b0}},
        '{dlme_pkg::OP_TRN,  6'd0,  6'd0,  1'b0, 32'h0,        0, '{32'h0, 1'b0}},
        '{dlme_pkg::OP_RD_V, 6'd0,  6'd1,  1'b1, 32'h0,        0, '{32'h0, 1'b0}},
        '{dlme_pkg::OP_UPD,  6'd0,  6'd0,  1'b0, 32'h0,        0, '{32'h0, 1'b0}},
        '{dlme_pkg::OP_RD_W, 6'd1,  6'd1,  1'b0, 32'h0,        0, '{32'h0, 1'b0}},
        '{dlme_pkg::OP_RD_W, 6'd0,  6'd0,  1'b0, 32'h0,        0, '{32'h0, 1'b0}}
    };

    int phase_rows[] = '{64, 1, 0, 5, 127, 3, 2, 6, 64, 4};
    int phase_cols[] = '{64, 1, 7, 0, 3, 127, 2, 5, 64, 8};

    initial begin
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= dlme_pkg::REG_ROWS;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_operation   <= dlme_pkg::OP_WR_W;
        s_row_index   <= '0;
        s_col_index   <= '0;
        s_vector_pick <= 1'b0;
        s_value       <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // load the corner that sweeps and random reads stay inside
        for (int r = 0; r < LOAD_N; r++)
            for (int c = 0; c < LOAD_N; c++)
                send_req(dlme_pkg::OP_WR_W, 6'(r), 6'(c), 1'b0, rand_q16());
        for (int i = 0; i < LOAD_N; i++)
            send_req(dlme_pkg::OP_WR_R, 6'(i), 6'd0, 1'b0, rand_q16());
        for (int i = 0; i < LOAD_N; i++)
            send_req(dlme_pkg::OP_WR_C, 6'd0, 6'(i), 1'b0, rand_q16());

        set_counts(7'd2, 7'd2);
        foreach (directed[i])
            send_req(directed[i].op, directed[i].ri, directed[i].ci, directed[i].pick,
                     directed[i].val, directed[i].typed, directed[i].ans);

        foreach (phase_rows[p]) begin
            set_counts(7'(phase_rows[p]), 7'(phase_cols[p]));
            if (p == 1) long_hold_req = 1;
            for (int n = 0; n < 32; n++) begin
                dlme_pkg::op_t op;
                logic [5:0] ri, ci;
                op = dlme_pkg::op_t'($urandom_range(0, 7));
                if (op inside {dlme_pkg::OP_FWD, dlme_pkg::OP_TRN, dlme_pkg::OP_UPD}
                    && (phase_rows[p] > LOAD_N || phase_cols[p] > LOAD_N))
                    op = dlme_pkg::OP_RD_W;
                ri = 6'($urandom_range(0, LOAD_N - 1));
                ci = 6'($urandom_range(0, LOAD_N - 1));
                send_req(op, ri, ci, 1'($urandom_range(0, 1)), rand_q16());
            end
            // sender holds back until the block has drained
            wait_idle();
        end

        s_valid <= 1'b0;
        wait_idle();
        repeat (50) @(posedge aclk);
        $display("Run covered %0d requests, %0d sweeps, %0d saturated results, %0d cycles",
                 accepted, sweeps, sat_seen, cycles);
        $display("Counts swept from zero through above maximum; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/dlme_pkg.sv
rtl/dense_layer_matrix_engine_top.sv
verif/dense_layer_matrix_engine_top_tb.sv
